>>> hw/rtl/lsw_pkg.sv
package lsw_pkg;

  // Scan geometry and sine table resolution.
  localparam int MAX_BEAMS       = 4096;
  localparam int SINE_TABLE_BITS = 10;

  // The table holds one quarter wave; the peak of the quarter is kept apart.
  localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
  localparam int QUARTER_ENTRIES = 1 << QUARTER_BITS;
  localparam int LOW_BITS        = 16 - SINE_TABLE_BITS;
  localparam int QUARTER_STEP    = 1 << LOW_BITS;

  // Angle of a quarter turn in binary angle units.
  localparam logic [15:0] QUARTER_ANGLE = 16'h4000;
  localparam logic [14:0] QUARTER_TURN  = 15'h4000;

  // Odd polynomial coefficients of the quarter-wave sine, Q2.30.
  localparam longint unsigned SIN_C1 = 64'd1686629713;
  localparam longint unsigned SIN_C3 = 64'd693598668;
  localparam longint unsigned SIN_C5 = 64'd85569306;
  localparam longint unsigned SIN_C7 = 64'd5026994;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ANGLE_STEP = 3'd0,
    REG_QUAT_X     = 3'd1,
    REG_QUAT_Y     = 3'd2,
    REG_QUAT_Z     = 3'd3,
    REG_QUAT_W     = 3'd4,
    REG_POSE_X     = 3'd5,
    REG_POSE_Y     = 3'd6,
    REG_POSE_Z     = 3'd7
  } cfg_reg_t;

  localparam logic signed [15:0] QUAT_W_RESET = 16'sd32767;

  typedef logic [14:0] sin_table_t [QUARTER_ENTRIES];

  // Magnitude of the sine for a quarter-wave position q in 0..16384.
  function automatic logic [14:0] sine_quarter(input int unsigned q);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    x  = longint'(q) << 16;
    x2 = (x * x) >> 30;
    t  = SIN_C7;
    t  = SIN_C5 - ((x2 * t) >> 30);
    t  = SIN_C3 - ((x2 * t) >> 30);
    t  = SIN_C1 - ((x2 * t) >> 30);
    s  = (x * t) >> 30;
    v  = (s + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return 15'(v);
  endfunction

  function automatic sin_table_t build_sin_table();
    sin_table_t tbl;
    for (int i = 0; i < QUARTER_ENTRIES; i++) begin
      tbl[i] = sine_quarter(i * QUARTER_STEP);
    end
    return tbl;
  endfunction

  localparam sin_table_t  SIN_TABLE = build_sin_table();
  localparam logic [14:0] SIN_PEAK  = sine_quarter(32'd16384);

  // Sine of a 16-bit binary angle in Q1.15, angle truncated to table steps.
  function automatic logic signed [15:0] sin_lookup(input logic [15:0] a);
    logic [1:0]  quarter;
    logic [13:0] r;
    logic [14:0] q;
    logic [14:0] mag;
    quarter = a[15:14];
    r       = {a[13:LOW_BITS], LOW_BITS'(0)};
    q       = quarter[0] ? (QUARTER_TURN - {1'b0, r}) : {1'b0, r};
    mag     = q[14] ? SIN_PEAK : SIN_TABLE[q[13:LOW_BITS]];
    return quarter[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
  endfunction

endpackage

>>> hw/rtl/lidar_scan_to_world_points_unit.sv
// Channel  Direction  Contents
// s_*      in         tdata: range_mm[15:0], beam_index[27:16]; tuser: range_invalid
// m_*      out        tdata: world_x[31:0], world_y[63:32], world_z[95:64]
// cfg_*    in         cfg_index selects the register, cfg_data holds its value
//
// One item per clock while the output is not stalled; a point leaves after
// its sample has passed the six-stage pipeline: angle multiply, table lookup,
// polar multiply, rotation multiply, sum and round, offset and saturate.
// Invalid samples and beams past the scan are dropped at the input.
// Reset clears the stage valid bits and loads the register reset values.
// A stage holds its item while the next one is full and blocked.
module lidar_scan_to_world_points_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // range_mm, beam_index, zero pad
  input  logic         s_tuser,   // range_invalid
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // world_x, world_y, world_z
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int STAGES = 6;

  localparam logic signed [32:0] MAT_ONE   = 33'sh0_2000_0000;
  localparam logic signed [66:0] ROUND_ADD = 67'sh0_0000_0800_0000_0000;
  localparam logic signed [33:0] SAT_MAX   = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] SAT_MIN   = -34'sh0_8000_0000;

  // Configuration registers.
  logic [15:0]        angle_step;
  logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
  logic signed [31:0] pose_x, pose_y, pose_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_step <= '0;
      quat_x     <= '0;
      quat_y     <= '0;
      quat_z     <= '0;
      quat_w     <= lsw_pkg::QUAT_W_RESET;
      pose_x     <= '0;
      pose_y     <= '0;
      pose_z     <= '0;
    end else if (cfg_we) begin
      unique case (lsw_pkg::cfg_reg_t'(cfg_index))
        lsw_pkg::REG_ANGLE_STEP: angle_step <= cfg_data[15:0];
        lsw_pkg::REG_QUAT_X:     quat_x     <= signed'(cfg_data[15:0]);
        lsw_pkg::REG_QUAT_Y:     quat_y     <= signed'(cfg_data[15:0]);
        lsw_pkg::REG_QUAT_Z:     quat_z     <= signed'(cfg_data[15:0]);
        lsw_pkg::REG_QUAT_W:     quat_w     <= signed'(cfg_data[15:0]);
        lsw_pkg::REG_POSE_X:     pose_x     <= signed'(cfg_data);
        lsw_pkg::REG_POSE_Y:     pose_y     <= signed'(cfg_data);
        lsw_pkg::REG_POSE_Z:     pose_z     <= signed'(cfg_data);
        default:                 angle_step <= angle_step;
      endcase
    end
  end

  // Quaternion products, registered ahead of the matrix sums.
  logic signed [31:0] qxqx, qyqy, qzqz, qxqy, qzqw, qxqz, qyqw, qyqz, qxqw;

  always_ff @(posedge clk) begin
    qxqx <= quat_x * quat_x;
    qyqy <= quat_y * quat_y;
    qzqz <= quat_z * quat_z;
    qxqy <= quat_x * quat_y;
    qzqw <= quat_z * quat_w;
    qxqz <= quat_x * quat_z;
    qyqw <= quat_y * quat_w;
    qyqz <= quat_y * quat_z;
    qxqw <= quat_x * quat_w;
  end

  // Rotation matrix in Q2.29 with the factor two folded in.
  logic signed [32:0] r11, r12, r21, r22, r31, r32;

  always_ff @(posedge clk) begin
    r11 <= MAT_ONE - (33'(qyqy) + 33'(qzqz));
    r12 <= 33'(qxqy) - 33'(qzqw);
    r21 <= 33'(qxqy) + 33'(qzqw);
    r22 <= MAT_ONE - (33'(qxqx) + 33'(qzqz));
    r31 <= 33'(qxqz) - 33'(qyqw);
    r32 <= 33'(qyqz) + 33'(qxqw);
  end

  // Stage handshake: a stage loads when it is empty or the next one moves.
  logic [STAGES-1:0] stage_valid;
  logic [STAGES-1:0] stage_en;
  logic              in_keep;

  always_comb begin
    stage_en[STAGES-1] = !stage_valid[STAGES-1] || m_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !stage_valid[k] || stage_en[k+1];
    end
  end

  assign s_tready = stage_en[0];
  assign m_tvalid = stage_valid[STAGES-1];
  assign in_keep  = !s_tuser && (32'(s_tdata[27:16]) < lsw_pkg::MAX_BEAMS);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_en[0]) begin
        stage_valid[0] <= s_tvalid && in_keep;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (stage_en[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  // Stage 1: beam angle, wrapped to 16 bits.
  logic [15:0] s1_range;
  logic [15:0] s1_angle;
  logic [27:0] angle_full;

  assign angle_full = s_tdata[27:16] * angle_step;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      s1_range <= s_tdata[15:0];
      s1_angle <= angle_full[15:0];
    end
  end

  // Stage 2: sine and cosine from the quarter-wave table.
  logic [15:0]        s2_range;
  logic signed [15:0] s2_sin, s2_cos;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      s2_range <= s1_range;
      s2_sin   <= lsw_pkg::sin_lookup(s1_angle);
      s2_cos   <= lsw_pkg::sin_lookup(16'(s1_angle + lsw_pkg::QUARTER_ANGLE));
    end
  end

  // Stage 3: local point in Q15 millimetres.
  logic signed [32:0] s3_lx, s3_ly;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      s3_lx <= signed'({1'b0, s2_range}) * s2_cos;
      s3_ly <= signed'({1'b0, s2_range}) * s2_sin;
    end
  end

  // Stage 4: rotation products.
  logic signed [65:0] p11, p12, p21, p22, p31, p32;

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      p11 <= r11 * s3_lx;
      p12 <= r12 * s3_ly;
      p21 <= r21 * s3_lx;
      p22 <= r22 * s3_ly;
      p31 <= r31 * s3_lx;
      p32 <= r32 * s3_ly;
    end
  end

  // Stage 5: row sums, rounded half up from 44 fractional bits.
  logic signed [66:0] acc_x, acc_y, acc_z;
  logic signed [22:0] s5_x, s5_y, s5_z;

  assign acc_x = 67'(p11) + 67'(p12) + ROUND_ADD;
  assign acc_y = 67'(p21) + 67'(p22) + ROUND_ADD;
  assign acc_z = 67'(p31) + 67'(p32) + ROUND_ADD;

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      s5_x <= 23'(acc_x >>> 44);
      s5_y <= 23'(acc_y >>> 44);
      s5_z <= 23'(acc_z >>> 44);
    end
  end

  // Stage 6: pose offset and saturation into the output register.
  logic signed [33:0] sum_x, sum_y, sum_z;
  logic signed [31:0] world_x, world_y, world_z;

  assign sum_x = 34'(s5_x) + 34'(pose_x);
  assign sum_y = 34'(s5_y) + 34'(pose_y);
  assign sum_z = 34'(s5_z) + 34'(pose_z);

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      world_x <= (sum_x > SAT_MAX) ? 32'(SAT_MAX) :
                 (sum_x < SAT_MIN) ? 32'(SAT_MIN) : 32'(sum_x);
      world_y <= (sum_y > SAT_MAX) ? 32'(SAT_MAX) :
                 (sum_y < SAT_MIN) ? 32'(SAT_MIN) : 32'(sum_y);
      world_z <= (sum_z > SAT_MAX) ? 32'(SAT_MAX) :
                 (sum_z < SAT_MIN) ? 32'(SAT_MIN) : 32'(sum_z);
    end
  end

  assign m_tdata = {world_z, world_y, world_x};

endmodule

>>> tb/sv/tb_lidar_scan_to_world_points_unit.sv
`timescale 1ns / 1ps

module tb_lidar_scan_to_world_points_unit;

  localparam int ITEMS_PER_PHASE = 172;
  localparam int RANDOM_PHASES   = 10;
  localparam int HOLD_CYCLES     = 200;
  localparam int SETTLE_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT  = 2000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } world_point_t;

  // Pose state and the queue of world points still owed by the block.
  class world_point_predictor;
    logic [15:0]        angle_step;
    logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
    logic signed [31:0] pose_x, pose_y, pose_z;
    world_point_t       pending_points[$];
    int                 mismatches;

    function new();
      angle_step = '0;
      quat_x = '0;
      quat_y = '0;
      quat_z = '0;
      quat_w = lsw_pkg::QUAT_W_RESET;
      pose_x = '0;
      pose_y = '0;
      pose_z = '0;
      mismatches = 0;
    endfunction

    function void set_reg(lsw_pkg::cfg_reg_t idx, logic [31:0] value);
      case (idx)
        lsw_pkg::REG_ANGLE_STEP: angle_step = value[15:0];
        lsw_pkg::REG_QUAT_X:     quat_x = value[15:0];
        lsw_pkg::REG_QUAT_Y:     quat_y = value[15:0];
        lsw_pkg::REG_QUAT_Z:     quat_z = value[15:0];
        lsw_pkg::REG_QUAT_W:     quat_w = value[15:0];
        lsw_pkg::REG_POSE_X:     pose_x = value;
        lsw_pkg::REG_POSE_Y:     pose_y = value;
        lsw_pkg::REG_POSE_Z:     pose_z = value;
        default: ;
      endcase
    endfunction

    // Q1.15 sine from the quarter-wave polynomial, angle cut to table steps.
    function longint table_sine(logic [15:0] ang);
      logic [15:0]     a;
      logic [1:0]      quad;
      longint unsigned pos, x, x2, poly, s, mag;
      a    = ang & ~16'((1 << (16 - lsw_pkg::SINE_TABLE_BITS)) - 1);
      quad = a[15:14];
      pos  = quad[0] ? (64'd16384 - 64'(a[13:0])) : 64'(a[13:0]);
      x    = pos << 16;
      x2   = (x * x) >> 30;
      poly = lsw_pkg::SIN_C5 - ((x2 * lsw_pkg::SIN_C7) >> 30);
      poly = lsw_pkg::SIN_C3 - ((x2 * poly) >> 30);
      poly = lsw_pkg::SIN_C1 - ((x2 * poly) >> 30);
      s    = (x * poly) >> 30;
      mag  = (s + 64'd16384) >> 15;
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      return quad[1] ? -longint'(mag) : longint'(mag);
    endfunction

    // Round from 44 fraction bits to mm, add the offset, clamp to 32 bits.
    function logic signed [31:0] to_mm(longint acc, logic signed [31:0] offset);
      longint m;
      m = ((acc + (longint'(1) <<< 43)) >>> 44) + longint'(offset);
      if (m > 64'sd2147483647) begin
        m = 64'sd2147483647;
      end else if (m < -64'sd2147483648) begin
        m = -64'sd2147483648;
      end
      return 32'(m);
    endfunction

    function void note_sample(logic [15:0] rng, logic [11:0] beam, logic invalid);
      logic [15:0]  ang;
      longint       qx, qy, qz, qw, unit, lx, ly;
      longint       r11, r12, r21, r22, r31, r32;
      world_point_t pt;
      if (invalid || beam >= lsw_pkg::MAX_BEAMS) begin
        return;
      end
      ang  = 16'(32'(beam) * 32'(angle_step));
      lx   = longint'(rng) * table_sine(16'(ang + 16'h4000));
      ly   = longint'(rng) * table_sine(ang);
      qx   = longint'(quat_x);
      qy   = longint'(quat_y);
      qz   = longint'(quat_z);
      qw   = longint'(quat_w);
      unit = longint'(1) <<< 29;
      // Rotation matrix in Q2.29 with the factor of two folded in.
      r11  = unit - (qy * qy + qz * qz);
      r12  = qx * qy - qz * qw;
      r21  = qx * qy + qz * qw;
      r22  = unit - (qx * qx + qz * qz);
      r31  = qx * qz - qy * qw;
      r32  = qy * qz + qx * qw;
      pt.x = to_mm(r11 * lx + r12 * ly, pose_x);
      pt.y = to_mm(r21 * lx + r22 * ly, pose_y);
      pt.z = to_mm(r31 * lx + r32 * ly, pose_z);
      pending_points = {pending_points, pt};
    endfunction

    task report(string what);
      if (mismatches < 50) begin
        $display("MISMATCH at %0t: %s", $realtime, what);
      end
      mismatches++;
    endtask

    task check_point(logic [95:0] word);
      world_point_t want;
      world_point_t got;
      got.x = word[31:0];
      got.y = word[63:32];
      got.z = word[95:64];
      if (pending_points.size() == 0) begin
        report($sformatf("unexpected point (%0d, %0d, %0d)", got.x, got.y, got.z));
      end else begin
        want = pending_points.pop_front();
        if (got.x !== want.x) begin
          report($sformatf("world_x got %0d, want %0d", got.x, want.x));
        end
        if (got.y !== want.y) begin
          report($sformatf("world_y got %0d, want %0d", got.y, want.y));
        end
        if (got.z !== want.z) begin
          report($sformatf("world_z got %0d, want %0d", got.z, want.z));
        end
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // range_mm, beam_index, zero pad
  logic        s_tuser = 1'b0; // range_invalid
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;        // world_x, world_y, world_z
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  world_point_predictor pred = new();
  bit hold_request = 1'b0;
  bit calm = 1'b0;

  lidar_scan_to_world_points_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Offer one sample, sometimes after a short gap, and wait until it is taken.
  task automatic send_sample(input logic [15:0] rng, input logic [11:0] beam,
                             input logic invalid);
    logic taken;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      s_tuser  <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, beam, rng};
    s_tuser  <= invalid;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end
    pred.note_sample(rng, beam, invalid);
  endtask

  // Stop offering and wait for every owed point to come out.
  task automatic drain_points();
    s_tvalid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pred.pending_points.size() != 0);
  endtask

  // Dropped samples never enter the pipeline; drain owed points, then idle.
  task automatic settle();
    drain_points();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input lsw_pkg::cfg_reg_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    pred.set_reg(idx, value);
  endtask

  // Write the full pose; unused upper bits of short registers carry noise.
  task automatic load_config(input logic [15:0] step, input logic [15:0] qx,
                             input logic [15:0] qy, input logic [15:0] qz,
                             input logic [15:0] qw, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] pz);
    put_reg(lsw_pkg::REG_ANGLE_STEP, {16'($urandom), step});
    put_reg(lsw_pkg::REG_QUAT_X, {16'($urandom), qx});
    put_reg(lsw_pkg::REG_QUAT_Y, {16'($urandom), qy});
    put_reg(lsw_pkg::REG_QUAT_Z, {16'($urandom), qz});
    put_reg(lsw_pkg::REG_QUAT_W, {16'($urandom), qw});
    put_reg(lsw_pkg::REG_POSE_X, px);
    put_reg(lsw_pkg::REG_POSE_Y, py);
    put_reg(lsw_pkg::REG_POSE_Z, pz);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_q15();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_pose();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return $urandom;
      default: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [15:0] pick_range();
    case ($urandom_range(0, 15))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Output side: take points and stall in bursts or in one long hold-off.
  initial begin : receiver
    logic [95:0] word;
    logic        took;
    int          stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      took = m_tvalid && m_tready;
      word = m_tdata;
      @(posedge clk);
      if (took) begin
        pred.check_point(word);
      end
      if (hold_request) begin
        stall_left   = HOLD_CYCLES;
        hold_request = 1'b0;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (rst) begin
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Give up when no item moves on either side for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] rng;
    logic [11:0] beam;
    logic [11:0] scan_start;
    logic        invalid;
    bit          scan_like;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset pose: identity rotation, zero step, so every beam points along x.
    send_sample(16'd0, 12'd0, 1'b0);
    send_sample(16'hFFFF, 12'hFFF, 1'b0);
    send_sample(16'hFFFF, 12'd0, 1'b1);
    send_sample(16'd12345, 12'd7, 1'b0);
    settle();

    // Extreme quaternion and offsets that drive x and y into saturation.
    load_config(16'd1000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    send_sample(16'hFFFF, 12'd0, 1'b0);
    send_sample(16'hFFFF, 12'd16, 1'b0);
    send_sample(16'hFFFF, 12'd33, 1'b0);
    send_sample(16'hFFFF, 12'hFFF, 1'b0);
    send_sample(16'd500, 12'd3, 1'b1);
    settle();

    // Quarter-turn step lands exactly on each axis, including the sine peak.
    load_config(16'h4000, 16'h0000, 16'h0000, 16'h5A82, 16'h5A82,
                32'hFFFF_FC18, 32'd2000, 32'h7FFF_FFFF);
    send_sample(16'hFFFF, 12'd0, 1'b0);
    send_sample(16'hFFFF, 12'd1, 1'b0);
    send_sample(16'hFFFF, 12'd2, 1'b0);
    send_sample(16'hFFFF, 12'd3, 1'b0);
    send_sample(16'd1, 12'd5, 1'b0);
    send_sample(16'hFFFF, 12'd4, 1'b1);
    settle();

    // Largest step: the beam angle wraps around many times over the scan.
    load_config(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                32'd0, 32'd0, 32'hFFFF_FFFB);
    send_sample(16'hFFFF, 12'hFFF, 1'b0);
    send_sample(16'd1, 12'd1, 1'b0);
    send_sample(16'd40000, 12'd2048, 1'b0);
    send_sample(16'd777, 12'd100, 1'b0);
    settle();

    // Random poses, each followed by a stream of samples.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 3))
        0: rng = 16'h0000;
        1: rng = 16'hFFFF;
        default: rng = 16'($urandom);
      endcase
      load_config(rng, pick_q15(), pick_q15(), pick_q15(), pick_q15(),
                  pick_pose(), pick_pose(), pick_pose());
      if (phase == 1) begin
        hold_request = 1'b1;
      end
      if (phase == RANDOM_PHASES - 1) begin
        calm = 1'b1;
      end
      scan_like  = (phase % 2 == 0);
      scan_start = 12'($urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        rng     = pick_range();
        beam    = scan_like ? 12'(scan_start + n) : 12'($urandom);
        invalid = ($urandom_range(0, 7) == 0);
        send_sample(rng, beam, invalid);
        // Now and then the sensor pauses until the pipeline has emptied.
        if (n % 60 == 59) begin
          drain_points();
        end
      end
      settle();
    end

    if (pred.pending_points.size() != 0) begin
      pred.report($sformatf("%0d points never came out", pred.pending_points.size()));
    end
    if (pred.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
